// ===== rtl/aus_pkg.sv =====
// Shared types and constants for the autoscale rung-select block.
// Used by aus_div, aus_log and the top module under rtl/.
package aus_pkg;

  localparam int LADDER_DEPTH  = 16;
  localparam int LOG_FRAC_BITS = 16;

  localparam int RUNG_AW  = (LADDER_DEPTH > 1) ? $clog2(LADDER_DEPTH) : 1;
  localparam int RCNT_W   = $clog2(LADDER_DEPTH + 1);
  localparam int NORM_STEPS = 6;
  localparam int LOG_STEPS  = NORM_STEPS + LOG_FRAC_BITS;
  localparam int LCNT_W   = $clog2(LOG_STEPS + 1);
  localparam int LOG_W    = 6 + LOG_FRAC_BITS;
  localparam int SCORE_W  = LOG_W + 2;

  localparam logic [63:0] LOWER_RST = 64'd4294967296;
  localparam logic [63:0] UPPER_RST = 64'd4294967296000;

  typedef enum logic [1:0] {
    CFG_LOWER  = 2'd0,
    CFG_UPPER  = 2'd1,
    CFG_LENGTH = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_CHOSEN  = 2'd0,
    ST_KEEP    = 2'd1,
    ST_BAD     = 2'd2,
    ST_WRITTEN = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_LLO, S_LLO_W, S_LHI, S_LHI_W, S_RD, S_FCHK,
    S_DIV_W, S_LV, S_LV_W, S_NEXT, S_FIN
  } seq_state_e;

  typedef struct packed {
    logic               mode;
    logic [3:0]         rung_index;
    logic [63:0]        rung_factor;
    logic signed [63:0] query_val;
  } aus_in_t;

  typedef struct packed {
    status_e    status;
    logic [3:0] chosen_rank;
    logic       scaled_in_range;
  } aus_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_st_t;

endpackage

// ===== rtl/aus_ram.sv =====
// Generic single-port-write RAM with registered read.
// No dependencies.
module aus_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/aus_div.sv =====
// Bit-serial Q32.32 divider: floor(a * 2^32 / f), saturating, one bit a cycle.
// Depends on aus_pkg.
module aus_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [63:0]      a_i,
  input  logic [63:0]      f_i,
  output aus_pkg::unit_st_t st_o,
  output logic [63:0]      q_o
);
  import aus_pkg::*;

  logic [63:0] rem_q, rem_d, sh_q, sh_d, q_q, q_d, f_q, f_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [64:0] trial;
  logic        ge;

  always_comb begin
    rem_d  = rem_q;
    sh_d   = sh_q;
    q_d    = q_q;
    f_d    = f_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, sh_q[63]};
    ge     = trial >= {1'b0, f_q};
    if (start_i) begin
      f_d   = f_i;
      cnt_d = '0;
      if (a_i[63:32] >= f_i[31:0] && f_i[63:32] == '0) begin
        q_d    = '1;
        done_d = 1'b1;
      end else begin
        rem_d  = {32'b0, a_i[63:32]};
        sh_d   = {a_i[31:0], 32'b0};
        q_d    = '0;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = ge ? 64'(trial - {1'b0, f_q}) : trial[63:0];
      sh_d  = {sh_q[62:0], 1'b0};
      q_d   = {q_q[62:0], ge};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    q_q   <= q_d;
    f_q   <= f_d;
  end

  assign st_o = '{busy: busy_q, done: done_q};
  assign q_o  = q_q;

`ifndef ASSERT_OFF
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("divider restarted while busy");
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < f_q) else $error("divider remainder not below factor");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done held");
`endif

endmodule

// ===== rtl/aus_log.sv =====
// Iterative fixed-point log2 of a positive Q32.32 word: a six-step leading-zero
// search, then one squaring per fraction bit. Depends on aus_pkg.
module aus_log (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [63:0]                         v_i,
  output aus_pkg::unit_st_t                   st_o,
  output logic signed [aus_pkg::LOG_W-1:0]    l_o
);
  import aus_pkg::*;

  logic [63:0]              x_q, x_d, x_n;
  logic [5:0]               lz_q, lz_d, lz_n;
  logic [31:0]              m_q, m_d;
  logic [LOG_FRAC_BITS-1:0] frac_q, frac_d;
  logic [LCNT_W-1:0]        cnt_q, cnt_d;
  logic                     busy_q, busy_d, done_q, done_d;
  logic [63:0]              prod;
  logic [32:0]              sq;
  logic [5:0]               ipart;

  always_comb begin
    x_n  = x_q;
    lz_n = lz_q;
    case (cnt_q)
      LCNT_W'(0): if (x_q[63:32] == '0) begin x_n = x_q << 32; lz_n = lz_q + 6'd32; end
      LCNT_W'(1): if (x_q[63:48] == '0) begin x_n = x_q << 16; lz_n = lz_q + 6'd16; end
      LCNT_W'(2): if (x_q[63:56] == '0) begin x_n = x_q << 8;  lz_n = lz_q + 6'd8;  end
      LCNT_W'(3): if (x_q[63:60] == '0) begin x_n = x_q << 4;  lz_n = lz_q + 6'd4;  end
      LCNT_W'(4): if (x_q[63:62] == '0) begin x_n = x_q << 2;  lz_n = lz_q + 6'd2;  end
      LCNT_W'(5): if (!x_q[63])         begin x_n = x_q << 1;  lz_n = lz_q + 6'd1;  end
      default: ;
    endcase
  end

  always_comb begin
    x_d    = x_q;
    lz_d   = lz_q;
    m_d    = m_q;
    frac_d = frac_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    prod   = 64'(m_q) * 64'(m_q);
    sq     = prod[63:31];
    if (start_i) begin
      x_d    = v_i;
      lz_d   = '0;
      frac_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      cnt_d = cnt_q + LCNT_W'(1);
      if (cnt_q < LCNT_W'(NORM_STEPS)) begin
        x_d  = x_n;
        lz_d = lz_n;
        m_d  = x_n[63:32];
      end else begin
        frac_d = {frac_q[LOG_FRAC_BITS-2:0], sq[32]};
        m_d    = sq[32] ? sq[32:1] : sq[31:0];
      end
      if (cnt_q == LCNT_W'(LOG_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    lz_q   <= lz_d;
    m_q    <= m_d;
    frac_q <= frac_d;
  end

  // integer part is msb - 32 = 31 - lz, two's complement in six bits
  assign ipart = 6'd31 - lz_q;
  assign l_o   = {ipart, frac_q};
  assign st_o  = '{busy: busy_q, done: done_q};

`ifndef ASSERT_OFF
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("log restarted while busy");
  a_mant_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q > LCNT_W'(NORM_STEPS)) |-> m_q[31]) else $error("log mantissa lost msb");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("log done held");
`endif

endmodule

// ===== rtl/autoscale_unit_rung_select_top.sv =====
// A rung write or an early-exit query answers in the cycle after it is taken.
// A full query runs the two bound logs, then for each rung a RAM read and, for a nonzero
// factor, the divider and, unless the rung is passed over, the log unit.
// Throughput: one word at a time; the input stalls while a query runs or a result is stalled.
// Reset: bounds and ladder length return to defaults; the rung store is not cleared.
module autoscale_unit_rung_select_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  aus_pkg::aus_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output aus_pkg::aus_out_t out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [63:0]      cfg_data_i
);
  import aus_pkg::*;

  seq_state_e state_q, state_d;
  logic [63:0] lower_q, upper_q;
  logic [4:0]  length_q;
  logic [RCNT_W-1:0] r_q, r_d, n_q, n_d;
  logic [63:0] mag_q, mag_d, v_q, v_d;
  logic signed [LOG_W-1:0]   llo_q, llo_d;
  logic signed [SCORE_W-1:0] target_q, target_d;
  logic [SCORE_W-1:0] score_q, score_d;
  logic [RUNG_AW-1:0] best_q, best_d;
  logic have_in_q, have_in_d, have_any_q, have_any_d, inr_q, inr_d;
  aus_out_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  logic in_acc, out_free;
  logic [63:0] raw_mag, rdata, q_div;
  logic ram_we;
  logic log_start, div_start;
  logic [63:0] log_v;
  logic signed [LOG_W-1:0] log_l;
  unit_st_t log_st, div_st;
  logic signed [SCORE_W-1:0] two_l, diff;
  logic [SCORE_W-1:0] cand;
  logic v_inr;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q  <= LOWER_RST;
      upper_q  <= UPPER_RST;
      length_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LOWER:  lower_q  <= cfg_data_i;
        CFG_UPPER:  upper_q  <= cfg_data_i;
        CFG_LENGTH: length_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign raw_mag    = in_data_i.query_val[63] ? 64'(-in_data_i.query_val) : in_data_i.query_val;
  assign ram_we     = in_acc && !in_data_i.mode && (32'(in_data_i.rung_index) < LADDER_DEPTH);

  aus_ram #(.WIDTH(64), .DEPTH(LADDER_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (RUNG_AW'(in_data_i.rung_index)),
    .wdata_i (in_data_i.rung_factor),
    .raddr_i (r_q[RUNG_AW-1:0]),
    .rdata_o (rdata)
  );

  assign log_v = (state_q == S_LLO) ? lower_q : ((state_q == S_LHI) ? upper_q : v_q);

  aus_log u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .v_i     (log_v),
    .st_o    (log_st),
    .l_o     (log_l)
  );

  aus_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .a_i     (mag_q),
    .f_i     (rdata),
    .st_o    (div_st),
    .q_o     (q_div)
  );

  assign two_l = SCORE_W'(log_l) <<< 1;
  assign diff  = inr_q ? (two_l - target_q) : two_l;
  assign cand  = diff[SCORE_W-1] ? SCORE_W'(-diff) : SCORE_W'(diff);
  assign v_inr = (q_div >= lower_q) && (q_div < upper_q);

  always_comb begin
    state_d     = state_q;
    r_d         = r_q;
    n_d         = n_q;
    mag_d       = mag_q;
    v_d         = v_q;
    llo_d       = llo_q;
    target_d    = target_q;
    score_d     = score_q;
    best_d      = best_q;
    have_in_d   = have_in_q;
    have_any_d  = have_any_q;
    inr_d       = inr_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    log_start   = 1'b0;
    div_start   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          out_d = '{status: ST_KEEP, chosen_rank: 4'd0, scaled_in_range: 1'b0};
          mag_d = raw_mag;
          n_d   = (32'(length_q) > LADDER_DEPTH) ? RCNT_W'(LADDER_DEPTH) : RCNT_W'(length_q);
          if (!in_data_i.mode) begin
            out_d.status = ST_WRITTEN;
            out_valid_d  = 1'b1;
          end else if (length_q == '0) begin
            out_valid_d = 1'b1;
          end else if (lower_q == '0 || upper_q <= lower_q) begin
            out_d.status = ST_BAD;
            out_valid_d  = 1'b1;
          end else if (raw_mag == '0) begin
            out_valid_d = 1'b1;
          end else begin
            state_d = S_LLO;
          end
        end
      end
      S_LLO: begin
        log_start = 1'b1;
        state_d   = S_LLO_W;
      end
      S_LLO_W: if (log_st.done) begin
        llo_d   = log_l;
        state_d = S_LHI;
      end
      S_LHI: begin
        log_start = 1'b1;
        state_d   = S_LHI_W;
      end
      S_LHI_W: if (log_st.done) begin
        target_d   = SCORE_W'(llo_q) + SCORE_W'(log_l);
        r_d        = '0;
        have_in_d  = 1'b0;
        have_any_d = 1'b0;
        best_d     = '0;
        state_d    = S_RD;
      end
      S_RD: state_d = S_FCHK;
      S_FCHK: begin
        // skip rungs with no factor
        if (rdata == '0) begin
          state_d = S_NEXT;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV_W;
        end
      end
      S_DIV_W: if (div_st.done) begin
        v_d   = q_div;
        inr_d = v_inr;
        if (q_div == '0 || (!v_inr && have_in_q)) begin
          state_d = S_NEXT;
        end else begin
          state_d = S_LV;
        end
      end
      S_LV: begin
        log_start = 1'b1;
        state_d   = S_LV_W;
      end
      S_LV_W: if (log_st.done) begin
        if (inr_q) begin
          if (!have_in_q || cand < score_q) begin
            best_d = r_q[RUNG_AW-1:0]; score_d = cand; have_in_d = 1'b1; have_any_d = 1'b1;
          end
        end else if (!have_any_q || cand < score_q) begin
          best_d = r_q[RUNG_AW-1:0]; score_d = cand; have_any_d = 1'b1;
        end
        state_d = S_NEXT;
      end
      S_NEXT: begin
        r_d     = r_q + RCNT_W'(1);
        state_d = (r_q + RCNT_W'(1) >= n_q) ? S_FIN : S_RD;
      end
      S_FIN: if (out_free) begin
        if (have_any_q) begin
          out_d = '{status: ST_CHOSEN, chosen_rank: 4'(best_q), scaled_in_range: have_in_q};
        end
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      r_q         <= '0;
      have_in_q   <= 1'b0;
      have_any_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      r_q         <= r_d;
      have_in_q   <= have_in_d;
      have_any_q  <= have_any_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    mag_q    <= mag_d;
    v_q      <= v_d;
    llo_q    <= llo_d;
    target_q <= target_d;
    score_q  <= score_d;
    best_q   <= best_d;
    inr_q    <= inr_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> state_q == S_IDLE) else $error("word taken during a query");
  a_plain_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != ST_CHOSEN) |->
    (out_data_o.chosen_rank == 4'd0 && !out_data_o.scaled_in_range))
    else $error("rank or range set without a chosen rung");
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == S_FIN || $past(in_acc)))
    else $error("result appeared without a source");
  a_units_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(log_st.busy && div_st.busy)) else $error("log and divider both busy");
`endif

endmodule
